### rtl/atrd_pkg.sv
// ----------------------------------------------------------------------------
// AT response terminator detector package
// Shared beat types, recognizer state codes, result kinds and the table of
// expected characters for the fixed parts of the final result lines.
// ----------------------------------------------------------------------------
package atrd_pkg;

  localparam int LEN_W   = 10;
  localparam int STATE_W = 5;

  // Result kinds.
  localparam logic [1:0] KIND_OK       = 2'd0;
  localparam logic [1:0] KIND_ERROR    = 2'd1;
  localparam logic [1:0] KIND_CME      = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  // Destination codes.
  localparam logic [1:0] DEST_NONE = 2'd0;
  localparam logic [1:0] DEST_AT   = 2'd1;
  localparam logic [1:0] DEST_GPS  = 2'd2;

  // Beat function codes.
  localparam logic FUNC_RX_BYTE = 1'b0;
  localparam logic FUNC_COMMAND = 1'b1;

  // Characters.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Recognizer states. The ones not named here are steps of a strict
  // sequence that advance on the character from want_char().
  localparam logic [STATE_W-1:0] ST_SEEK_CR = 5'd0;
  localparam logic [STATE_W-1:0] ST_SEEK_LF = 5'd1;
  localparam logic [STATE_W-1:0] ST_FIRST   = 5'd2;
  localparam logic [STATE_W-1:0] ST_OK_K    = 5'd3;
  localparam logic [STATE_W-1:0] ST_OK_LF   = 5'd5;
  localparam logic [STATE_W-1:0] ST_ER_R1   = 5'd6;
  localparam logic [STATE_W-1:0] ST_ER_LF   = 5'd11;
  localparam logic [STATE_W-1:0] ST_CME_C   = 5'd12;
  localparam logic [STATE_W-1:0] ST_CME_CR  = 5'd22;
  localparam logic [STATE_W-1:0] ST_CME_LF  = 5'd23;
  localparam logic [STATE_W-1:0] ST_LAST    = 5'd23;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       requester;
  } item_t;

  typedef struct packed {
    logic [1:0]       response_kind;
    logic [LEN_W-1:0] text_length;
    logic [1:0]       destination;
  } result_t;

  // Expected character in each strict-sequence state.
  function automatic logic [7:0] want_char(input logic [STATE_W-1:0] s);
    logic [7:0] c;
    case (s)
      5'd3:    c = CH_K;
      5'd4:    c = CH_CR;
      5'd6:    c = CH_R;
      5'd7:    c = CH_R;
      5'd8:    c = CH_O;
      5'd9:    c = CH_R;
      5'd10:   c = CH_CR;
      5'd12:   c = CH_C;
      5'd13:   c = CH_M;
      5'd14:   c = CH_E;
      5'd15:   c = CH_SPACE;
      5'd16:   c = CH_E;
      5'd17:   c = CH_R;
      5'd18:   c = CH_R;
      5'd19:   c = CH_O;
      5'd20:   c = CH_R;
      5'd21:   c = CH_COLON;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### rtl/at_response_terminator_detector.sv
// ----------------------------------------------------------------------------
// AT response terminator detector
// Recognizes modem final result lines (OK, ERROR, +CME ERROR) in a byte stream,
// counts the response bytes and reports who awaits the answer.
// ----------------------------------------------------------------------------
// A result is registered and appears on the result port in the cycle after its byte beat.
// Throughput: one beat per cycle; the only stall comes from a held result.
// The recognizer state, byte count and destination update in a single pass.
// Reset (synchronous, rst high) returns the recognizer to seeking a carriage
// return, clears the count and destination, and empties the result register.

module at_response_terminator_detector #(
  parameter int MAX_TEXT = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  atrd_pkg::item_t  item,
  output logic             result_valid,
  input  logic             result_stall,
  output atrd_pkg::result_t result
);

  // Recognizer and response bookkeeping.
  logic [atrd_pkg::STATE_W-1:0] parse_state, parse_state_next;
  logic [atrd_pkg::LEN_W-1:0]   accumulated_length, accumulated_length_next;
  logic [1:0]                   pending_destination, pending_destination_next;

  logic                         item_take;
  logic [atrd_pkg::LEN_W-1:0]   length_inc;
  logic                         match;
  logic [1:0]                   match_kind;
  logic                         over;
  logic                         emit;
  atrd_pkg::result_t            result_next;

  // The result register frees up in the same cycle its beat is taken, so a new
  // item is stalled only while a finished result is held by the far side.
  assign item_stall = result_valid && result_stall;
  assign item_take  = item_valid && !item_stall;

  assign length_inc = accumulated_length + atrd_pkg::LEN_W'(1);

  // Recognizer: one step per received byte.
  always_comb begin
    parse_state_next = parse_state;
    match            = 1'b0;
    match_kind       = atrd_pkg::KIND_OK;
    case (parse_state)
      atrd_pkg::ST_SEEK_CR: begin
        if (item.rx_byte == atrd_pkg::CH_CR) begin
          parse_state_next = atrd_pkg::ST_SEEK_LF;
        end
      end
      atrd_pkg::ST_SEEK_LF: begin
        if (item.rx_byte == atrd_pkg::CH_LF) begin
          parse_state_next = atrd_pkg::ST_FIRST;
        end else if (item.rx_byte == atrd_pkg::CH_CR) begin
          parse_state_next = atrd_pkg::ST_SEEK_LF;
        end else begin
          parse_state_next = atrd_pkg::ST_SEEK_CR;
        end
      end
      atrd_pkg::ST_FIRST: begin
        if (item.rx_byte == atrd_pkg::CH_O) begin
          parse_state_next = atrd_pkg::ST_OK_K;
        end else if (item.rx_byte == atrd_pkg::CH_E) begin
          parse_state_next = atrd_pkg::ST_ER_R1;
        end else if (item.rx_byte == atrd_pkg::CH_PLUS) begin
          parse_state_next = atrd_pkg::ST_CME_C;
        end else if (item.rx_byte == atrd_pkg::CH_CR) begin
          parse_state_next = atrd_pkg::ST_SEEK_LF;
        end else begin
          parse_state_next = atrd_pkg::ST_SEEK_CR;
        end
      end
      atrd_pkg::ST_OK_LF, atrd_pkg::ST_ER_LF, atrd_pkg::ST_CME_LF: begin
        // The final line feed decides; any other byte drops the line.
        match = (item.rx_byte == atrd_pkg::CH_LF);
        if (parse_state == atrd_pkg::ST_OK_LF) begin
          match_kind = atrd_pkg::KIND_OK;
        end else if (parse_state == atrd_pkg::ST_ER_LF) begin
          match_kind = atrd_pkg::KIND_ERROR;
        end else begin
          match_kind = atrd_pkg::KIND_CME;
        end
        parse_state_next = atrd_pkg::ST_SEEK_CR;
      end
      atrd_pkg::ST_CME_CR: begin
        // Free text after the colon runs until a carriage return.
        if (item.rx_byte == atrd_pkg::CH_CR) begin
          parse_state_next = atrd_pkg::ST_CME_LF;
        end
      end
      default: begin
        // Strict sequence steps advance on the expected character. Codes past
        // the last state cannot be reached and simply hold.
        if (parse_state <= atrd_pkg::ST_LAST) begin
          if (item.rx_byte == atrd_pkg::want_char(parse_state)) begin
            parse_state_next = parse_state + atrd_pkg::STATE_W'(1);
          end else begin
            parse_state_next = atrd_pkg::ST_SEEK_CR;
          end
        end
      end
    endcase
  end

  // A match takes precedence over an overflow on the same byte.
  assign over = (length_inc > atrd_pkg::LEN_W'(MAX_TEXT));
  assign emit = item_take && (item.func == atrd_pkg::FUNC_RX_BYTE) && (match || over);

  always_comb begin
    result_next.response_kind = match ? match_kind : atrd_pkg::KIND_OVERFLOW;
    result_next.text_length   = length_inc;
    result_next.destination   = pending_destination;
  end

  always_comb begin
    accumulated_length_next  = accumulated_length;
    pending_destination_next = pending_destination;
    if (item.func == atrd_pkg::FUNC_COMMAND) begin
      // A command restarts the count and records the requester; the
      // recognizer is left where it is.
      accumulated_length_next  = '0;
      pending_destination_next = item.requester ? atrd_pkg::DEST_GPS : atrd_pkg::DEST_AT;
    end else if (match || over) begin
      accumulated_length_next  = '0;
      pending_destination_next = atrd_pkg::DEST_NONE;
    end else begin
      accumulated_length_next  = length_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state         <= atrd_pkg::ST_SEEK_CR;
      accumulated_length  <= '0;
      pending_destination <= atrd_pkg::DEST_NONE;
      result_valid        <= 1'b0;
    end else begin
      if (item_take) begin
        accumulated_length  <= accumulated_length_next;
        pending_destination <= pending_destination_next;
        if (item.func == atrd_pkg::FUNC_RX_BYTE) begin
          parse_state <= parse_state_next;
        end
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload is only loaded with a new result beat.
  always_ff @(posedge clk) begin
    if (emit) begin
      result <= result_next;
    end
  end

endmodule

### rtl/atrd_checker.sv
// ----------------------------------------------------------------------------
// AT response terminator detector checker
// Port-level assertions for the detector, attached to it by a bind statement.
// ----------------------------------------------------------------------------
module atrd_checker #(
  parameter int MAX_TEXT = 512
) (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input atrd_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input atrd_pkg::result_t result
);

  // A held result beat keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // A command beat never produces a result.
  a_command_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (item.func == atrd_pkg::FUNC_COMMAND) |=> !result_valid)
    else $error("command beat produced a result");

  // An overflow result reports exactly one byte past the limit.
  a_overflow_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.response_kind == atrd_pkg::KIND_OVERFLOW)
      |-> result.text_length == atrd_pkg::LEN_W'(MAX_TEXT + 1))
    else $error("overflow result with wrong length");

  // Every result counts at least the line feed and names a legal destination.
  a_result_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.text_length != '0) && (result.destination != 2'd3))
    else $error("result with impossible length or destination");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind at_response_terminator_detector atrd_checker #(.MAX_TEXT(MAX_TEXT)) u_atrd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

### tb/sv/at_response_terminator_detector_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AT response terminator detector checker
// Watches both beat channels of the detector. It keeps its own copy of the
// recognizer, the byte count and the pending destination, predicts the final
// result of every accepted beat, and compares each result beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module at_response_terminator_detector_checker
  import atrd_pkg::*;
#(
  parameter int MAX_TEXT = 512
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      fail_count,
  output int      outstanding
);

  logic [STATE_W-1:0] line_state;
  logic [LEN_W-1:0]   byte_count;
  logic [1:0]         waiting_dest;
  logic [7:0]         seq_char [0:23];
  result_t            final_results[$];
  int                 mismatches;

  // Character that moves each strict-sequence state one step on.
  initial begin
    foreach (seq_char[i]) seq_char[i] = 8'h00;
    seq_char[3]  = CH_K;
    seq_char[4]  = CH_CR;
    seq_char[6]  = CH_R;
    seq_char[7]  = CH_R;
    seq_char[8]  = CH_O;
    seq_char[9]  = CH_R;
    seq_char[10] = CH_CR;
    seq_char[12] = CH_C;
    seq_char[13] = CH_M;
    seq_char[14] = CH_E;
    seq_char[15] = CH_SPACE;
    seq_char[16] = CH_E;
    seq_char[17] = CH_R;
    seq_char[18] = CH_R;
    seq_char[19] = CH_O;
    seq_char[20] = CH_R;
    seq_char[21] = CH_COLON;
  end

  task automatic predict_final_result(input item_t beat);
    logic [STATE_W-1:0] s;
    logic [7:0]         ch;
    logic [1:0]         kind;
    logic               matched;
    result_t            r;
    s       = line_state;
    ch      = beat.rx_byte;
    kind    = KIND_OK;
    matched = 1'b0;
    if (beat.func == FUNC_COMMAND) begin
      byte_count   = '0;
      waiting_dest = beat.requester ? DEST_GPS : DEST_AT;
    end else begin
      byte_count = byte_count + 1'b1;
      case (s)
        ST_SEEK_CR: begin
          if (ch == CH_CR) s = ST_SEEK_LF;
        end
        ST_SEEK_LF: begin
          if (ch == CH_LF) s = ST_FIRST;
          else if (ch != CH_CR) s = ST_SEEK_CR;
        end
        ST_FIRST: begin
          if (ch == CH_O) s = ST_OK_K;
          else if (ch == CH_E) s = ST_ER_R1;
          else if (ch == CH_PLUS) s = ST_CME_C;
          else if (ch == CH_CR) s = ST_SEEK_LF;
          else s = ST_SEEK_CR;
        end
        ST_OK_LF, ST_ER_LF, ST_CME_LF: begin
          matched = (ch == CH_LF);
          if (s == ST_OK_LF) kind = KIND_OK;
          else if (s == ST_ER_LF) kind = KIND_ERROR;
          else kind = KIND_CME;
          s = ST_SEEK_CR;
        end
        ST_CME_CR: begin
          if (ch == CH_CR) s = ST_CME_LF;
        end
        default: begin
          // Codes past the last state are never reached and simply hold.
          if (s <= ST_LAST) begin
            if (ch == seq_char[s]) s = s + 1'b1;
            else s = ST_SEEK_CR;
          end
        end
      endcase
      line_state = s;
      // A match wins over an overflow on the same byte; either one clears the count.
      if (matched || byte_count > MAX_TEXT) begin
        r.response_kind = matched ? kind : KIND_OVERFLOW;
        r.text_length   = byte_count;
        r.destination   = waiting_dest;
        final_results   = {final_results, r};
        byte_count   = '0;
        waiting_dest = DEST_NONE;
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      line_state   = ST_SEEK_CR;
      byte_count   = '0;
      waiting_dest = DEST_NONE;
      mismatches   = 0;
      final_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (final_results.size() == 0) begin
          mismatches++;
          $display({"%0t: unexpected result beat: expected no result,",
                    " got kind %0d length %0d destination %0d"},
                   $time, result.response_kind, result.text_length, result.destination);
        end else begin
          want = final_results[0];
          final_results.delete(0);
          if (result !== want) begin
            mismatches++;
            $display({"%0t: result mismatch: expected kind %0d length %0d destination %0d,",
                      " got kind %0d length %0d destination %0d"},
                     $time, want.response_kind, want.text_length, want.destination,
                     result.response_kind, result.text_length, result.destination);
          end
        end
      end
      if (item_valid && !item_stall) predict_final_result(item);
    end
    fail_count  <= mismatches;
    outstanding <= final_results.size();
  end

endmodule

### tb/sv/at_response_terminator_detector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AT response terminator detector testbench
// Feeds the detector modem byte streams and command events: a short directed
// opening, then random response lines, damaged lines, noise and two long runs
// that reach the text limit, under three patterns of sender and receiver
// idling. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module at_response_terminator_detector_tb;
  import atrd_pkg::*;

  localparam int TEXT_LIMIT  = 512;
  localparam int PHASE_BEATS = 470;

  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  item_t   item         = '0;
  logic    result_stall = 1'b0;
  logic    item_stall;
  logic    result_valid;
  result_t result;

  int fail_count;
  int outstanding;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_sent    = 0;

  // Beats of the line being built, sent in one go by send_line.
  item_t line_beats[$];

  at_response_terminator_detector #(
    .MAX_TEXT(TEXT_LIMIT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  at_response_terminator_detector_checker #(
    .MAX_TEXT(TEXT_LIMIT)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // A received byte. The requester bit is ignored here, so it is randomized.
  task automatic push_byte(input logic [7:0] b);
    item_t beat;
    beat.func      = FUNC_RX_BYTE;
    beat.rx_byte   = b;
    beat.requester = 1'($urandom);
    line_beats     = {line_beats, beat};
  endtask

  // A command event. The byte field is ignored here, so it is randomized.
  task automatic push_command(input logic req);
    item_t beat;
    beat.func      = FUNC_COMMAND;
    beat.rx_byte   = 8'($urandom);
    beat.requester = req;
    line_beats     = {line_beats, beat};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_crlf();
    push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  // Random bytes; with no_cr set a carriage return is turned into another byte,
  // which keeps the recognizer parked while it seeks or waits in +CME text.
  task automatic push_random(input int n, input bit no_cr);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if (no_cr && b == CH_CR) b = b ^ 8'h80;
      push_byte(b);
    end
  endtask

  // One complete final result line of the given kind, with its leading CR LF.
  task automatic push_final_line(input logic [1:0] kind);
    push_crlf();
    case (kind)
      KIND_OK: begin
        push_text("OK");
      end
      KIND_ERROR: begin
        push_text("ERROR");
      end
      default: begin
        push_text("+CME ERROR:");
        push_random($urandom_range(0, 12), 1'b1);
      end
    endcase
    push_crlf();
  endtask

  // Mostly characters that mean something to the recognizer.
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    case ($urandom_range(0, 13))
      0:       c = CH_CR;
      1:       c = CH_LF;
      2:       c = CH_O;
      3:       c = CH_K;
      4:       c = CH_E;
      5:       c = CH_R;
      6:       c = CH_PLUS;
      7:       c = CH_C;
      8:       c = CH_M;
      9:       c = CH_SPACE;
      10:      c = CH_COLON;
      default: c = 8'($urandom);
    endcase
    return c;
  endfunction

  // Sends one beat: an optional random gap, then valid held until accepted.
  // The stall sampled right after the edge is the value the block saw there.
  task automatic send_beat(input item_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_line();
    foreach (line_beats[i]) send_beat(line_beats[i]);
    line_beats.delete();
  endtask

  // A run long enough to reach the text limit. A CR followed by a plain byte
  // brings the recognizer back to seeking a CR from any state without a
  // result, so the count after the command is known exactly. With at_limit set
  // the line feed of an OK line is byte MAX_TEXT+1, where the match must win;
  // otherwise the filler alone runs past the limit and overflows.
  task automatic push_long_run(input bit at_limit);
    push_byte(CH_CR);
    push_byte(8'h78);
    push_command(1'($urandom));
    if (at_limit) begin
      push_random(TEXT_LIMIT + 1 - 6, 1'b1);
      push_final_line(KIND_OK);
    end else begin
      push_random(TEXT_LIMIT + 1 + $urandom_range(0, 20), 1'b1);
    end
  endtask

  initial begin
    int         phase_start;
    int         line_no;
    int         pick;
    int         mark;
    int         wait_cycles;
    logic [1:0] kind;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening: byte extremes, then an OK line for a plain AT command
    // and an ERROR line for a GPS command.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_command(1'b0);
    push_final_line(KIND_OK);
    push_command(1'b1);
    push_final_line(KIND_ERROR);
    send_line();

    // Random part in three idling phases: sender light and receiver heavy,
    // then the reverse, then no idling at all.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 59 : 0;
      recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 23 : 0;
      phase_start   = beats_sent;
      line_no       = 0;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        pick = $urandom_range(0, 99);
        kind = 2'($urandom_range(0, 2));
        if (line_no == 2 && phase < 2) begin
          push_long_run(phase == 1);
        end else if (pick < 65) begin
          // Well-formed response, mostly after a command, sometimes with echo.
          if ($urandom_range(0, 9) < 7) push_command(1'($urandom));
          if ($urandom_range(0, 3) == 0) push_random($urandom_range(1, 16), 1'b0);
          push_final_line(kind);
        end else if (pick < 85) begin
          // Damaged line: one byte replaced, or the tail cut off.
          if ($urandom_range(0, 1) == 0) push_command(1'($urandom));
          mark = line_beats.size();
          push_final_line(kind);
          if ($urandom_range(0, 1) == 0) begin
            line_beats[mark + $urandom_range(0, line_beats.size() - mark - 1)].rx_byte =
              8'($urandom);
          end else begin
            repeat ($urandom_range(1, 3)) void'(line_beats.pop_back());
          end
        end else begin
          // Noise, now and then broken up by a command.
          repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 15) == 0) push_command(1'($urandom));
            else push_byte(noise_char());
          end
        end
        send_line();
        line_no++;
      end
    end

    // Drain: wait for every predicted result before the verdict.
    item_valid  <= 1'b0;
    wait_cycles = 0;
    repeat (2) @(posedge clk);
    while (outstanding != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);

    if (outstanding != 0)
      $display("%0t: %0d expected results never arrived", $time, outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
rtl/atrd_pkg.sv
rtl/at_response_terminator_detector.sv
rtl/atrd_checker.sv
tb/sv/at_response_terminator_detector_checker.sv
tb/sv/at_response_terminator_detector_tb.sv
